FILE: sv/mre_pkg.sv
// Shared types and constants of the MIPS32 R-type execute block.
// Used by mre_alu and mips_r_type_execute; depends on nothing else.
package mre_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned REG_IDX_W = 5;
   localparam int unsigned REG_COUNT = 32;
   localparam int unsigned FUNCT_W = 6;
   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned REQ_DATA_W = 56;
   localparam int unsigned RSP_DATA_W = 80;

   localparam logic [CSR_INDEX_W-1:0] CSR_CODE_WINDOW_LOW = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CODE_WINDOW_HIGH = 4'd1;

   localparam logic [WORD_W-1:0] CODE_WINDOW_LOW_RESET = 32'h1000_0000;
   localparam logic [WORD_W-1:0] CODE_WINDOW_HIGH_RESET = 32'h1100_0000;
   localparam logic [WORD_W-1:0] LINK_OFFSET = 32'd8;

   localparam logic [FUNCT_W-1:0] FN_SLL = 6'h00;
   localparam logic [FUNCT_W-1:0] FN_SRL = 6'h02;
   localparam logic [FUNCT_W-1:0] FN_SRA = 6'h03;
   localparam logic [FUNCT_W-1:0] FN_SLLV = 6'h04;
   localparam logic [FUNCT_W-1:0] FN_SRLV = 6'h06;
   localparam logic [FUNCT_W-1:0] FN_SRAV = 6'h07;
   localparam logic [FUNCT_W-1:0] FN_JR = 6'h08;
   localparam logic [FUNCT_W-1:0] FN_JALR = 6'h09;
   localparam logic [FUNCT_W-1:0] FN_MFHI = 6'h10;
   localparam logic [FUNCT_W-1:0] FN_MTHI = 6'h11;
   localparam logic [FUNCT_W-1:0] FN_MFLO = 6'h12;
   localparam logic [FUNCT_W-1:0] FN_MTLO = 6'h13;
   localparam logic [FUNCT_W-1:0] FN_MULT = 6'h18;
   localparam logic [FUNCT_W-1:0] FN_MULTU = 6'h19;
   localparam logic [FUNCT_W-1:0] FN_ADD = 6'h20;
   localparam logic [FUNCT_W-1:0] FN_ADDU = 6'h21;
   localparam logic [FUNCT_W-1:0] FN_SUB = 6'h22;
   localparam logic [FUNCT_W-1:0] FN_SUBU = 6'h23;
   localparam logic [FUNCT_W-1:0] FN_AND = 6'h24;
   localparam logic [FUNCT_W-1:0] FN_OR = 6'h25;
   localparam logic [FUNCT_W-1:0] FN_XOR = 6'h26;
   localparam logic [FUNCT_W-1:0] FN_SLT = 6'h2A;
   localparam logic [FUNCT_W-1:0] FN_SLTU = 6'h2B;

   typedef enum logic [1:0] {
      FAULT_NONE = 2'd0,
      FAULT_OVERFLOW = 2'd1,
      FAULT_BAD_JUMP = 2'd2,
      FAULT_UNSUPPORTED = 2'd3
   } fault_type;

   typedef struct packed {
      logic [FUNCT_W-1:0]   kind;
      logic [REG_IDX_W-1:0] dest_index;
      logic [REG_IDX_W-1:0] shift_amount;
      logic [WORD_W-1:0]    pc;
      logic [WORD_W-1:0]    rs;
      logic [WORD_W-1:0]    rt;
      logic [WORD_W-1:0]    hi;
      logic [WORD_W-1:0]    lo;
      logic [WORD_W-1:0]    window_low;
      logic [WORD_W-1:0]    window_high;
   } alu_operand_type;

   typedef struct packed {
      logic                 write_enable;
      logic [REG_IDX_W-1:0] write_index;
      logic [WORD_W-1:0]    write_value;
      logic                 jump_taken;
      logic [WORD_W-1:0]    jump_target;
      fault_type            fault;
      logic                 hi_write;
      logic [WORD_W-1:0]    hi_value;
      logic                 lo_write;
      logic [WORD_W-1:0]    lo_value;
   } alu_result_type;

endpackage

FILE: sv/mre_alu.sv
// Execute datapath: shifter, adder, logic unit, comparator and multiplier.
// Depends on mre_pkg for the funct codes and the operand and result structs.
module mre_alu (
   input  mre_pkg::alu_operand_type op,
   output mre_pkg::alu_result_type  res
);
   import mre_pkg::*;

   logic [WORD_W-1:0]    sum;
   logic [WORD_W-1:0]    diff;
   logic [WORD_W:0]      mul_a;
   logic [WORD_W:0]      mul_b;
   logic [2*WORD_W+1:0]  product;
   logic                 is_signed_mul;
   logic [REG_IDX_W-1:0] var_shift;
   logic                 target_ok;
   logic                 wr;
   logic [WORD_W-1:0]    val;

   assign sum = op.rs + op.rt;
   assign diff = op.rs - op.rt;
   assign var_shift = op.rs[REG_IDX_W-1:0];

   // One 33x33 signed multiplier serves both mult and multu.
   assign is_signed_mul = (op.kind == FN_MULT);
   assign mul_a = {is_signed_mul & op.rs[WORD_W-1], op.rs};
   assign mul_b = {is_signed_mul & op.rt[WORD_W-1], op.rt};
   assign product = $signed(mul_a) * $signed(mul_b);

   assign target_ok = (op.rs[1:0] == 2'b00) && (op.rs >= op.window_low)
                      && (op.rs < op.window_high);

   always_comb begin
      wr = 1'b0;
      val = '0;
      res.jump_taken = 1'b0;
      res.jump_target = '0;
      res.fault = FAULT_NONE;
      res.hi_write = 1'b0;
      res.hi_value = op.rs;
      res.lo_write = 1'b0;
      res.lo_value = op.rs;
      unique case (op.kind)
         FN_SLL: begin wr = 1'b1; val = op.rt << op.shift_amount; end
         FN_SRL: begin wr = 1'b1; val = op.rt >> op.shift_amount; end
         FN_SRA: begin wr = 1'b1; val = $unsigned($signed(op.rt) >>> op.shift_amount); end
         FN_SLLV: begin wr = 1'b1; val = op.rt << var_shift; end
         FN_SRLV: begin wr = 1'b1; val = op.rt >> var_shift; end
         FN_SRAV: begin wr = 1'b1; val = $unsigned($signed(op.rt) >>> var_shift); end
         FN_JR: begin
            if (target_ok) begin
               res.jump_taken = 1'b1;
               res.jump_target = op.rs;
            end else begin
               res.fault = FAULT_BAD_JUMP;
            end
         end
         FN_JALR: begin
            if (target_ok) begin
               res.jump_taken = 1'b1;
               res.jump_target = op.rs;
               wr = 1'b1;
               val = op.pc + LINK_OFFSET;
            end else begin
               res.fault = FAULT_BAD_JUMP;
            end
         end
         FN_MFHI: begin wr = 1'b1; val = op.hi; end
         FN_MTHI: res.hi_write = 1'b1;
         FN_MFLO: begin wr = 1'b1; val = op.lo; end
         FN_MTLO: res.lo_write = 1'b1;
         FN_MULT, FN_MULTU: begin
            res.hi_write = 1'b1;
            res.lo_write = 1'b1;
            res.hi_value = product[2*WORD_W-1:WORD_W];
            res.lo_value = product[WORD_W-1:0];
         end
         FN_ADD: begin
            if (~(op.rs[WORD_W-1] ^ op.rt[WORD_W-1]) & (op.rs[WORD_W-1] ^ sum[WORD_W-1])) begin
               res.fault = FAULT_OVERFLOW;
            end else begin
               wr = 1'b1;
               val = sum;
            end
         end
         FN_ADDU: begin wr = 1'b1; val = sum; end
         FN_SUB: begin
            if ((op.rs[WORD_W-1] ^ op.rt[WORD_W-1]) & (op.rs[WORD_W-1] ^ diff[WORD_W-1])) begin
               res.fault = FAULT_OVERFLOW;
            end else begin
               wr = 1'b1;
               val = diff;
            end
         end
         FN_SUBU: begin wr = 1'b1; val = diff; end
         FN_AND: begin wr = 1'b1; val = op.rs & op.rt; end
         FN_OR: begin wr = 1'b1; val = op.rs | op.rt; end
         FN_XOR: begin wr = 1'b1; val = op.rs ^ op.rt; end
         FN_SLT: begin
            wr = 1'b1;
            val = {{(WORD_W-1){1'b0}}, $signed(op.rs) < $signed(op.rt)};
         end
         FN_SLTU: begin
            wr = 1'b1;
            val = {{(WORD_W-1){1'b0}}, op.rs < op.rt};
         end
         default: res.fault = FAULT_UNSUPPORTED;
      endcase

      // Register zero is never written; the rest of the instruction still acts.
      res.write_enable = wr && (op.dest_index != '0);
      res.write_index = res.write_enable ? op.dest_index : '0;
      res.write_value = res.write_enable ? val : '0;
   end

endmodule

FILE: sv/mips_r_type_execute.sv
// MIPS32 R-type execute block: register file memory, HI/LO and the result register.
// Depends on mre_pkg and mre_alu.
//
// One decoded R-type instruction is accepted per request and produces exactly
// one result. The block takes a new request every cycle while the result port
// does not stall. On the accepting edge the two source registers are read from
// a 32-entry register file held in a synchronous memory with registered reads.
// In the following cycle the instruction is executed, and when the execute stage
// advances the destination is written back while the result is loaded into the
// output register, from which it is presented on the rsp port. A write that
// lands on the same edge as a later instruction's read is forwarded, so
// dependent instructions may follow back to back. A 32-bit valid vector,
// cleared by reset, makes every register read as zero until written, so no
// clearing pass is needed. The register file has a single write port; a stalled
// result port holds the execute stage and then the request port. The user must
// write the code window registers through the csr port only while idle; the
// block itself does not enforce this.
module mips_r_type_execute (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata, from bit 0: first_index[5], second_index[5], dest_index[5],
   // shift_amount[5], pc[32], zero fill[4]
   input  logic [mre_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_tuser: kind[6]
   input  logic [mre_pkg::FUNCT_W-1:0]       req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // rsp_tdata, from bit 0: write_enable[1], write_index[5], write_value[32],
   // jump_taken[1], jump_target[32], fault[2], zero fill[7]
   output logic [mre_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mre_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mre_pkg::WORD_W-1:0]        csr_data
);
   import mre_pkg::*;

   logic [REG_IDX_W-1:0] req_first;
   logic [REG_IDX_W-1:0] req_second;
   logic                 req_fire;

   logic [WORD_W-1:0]    regs_mem [REG_COUNT];
   logic [REG_COUNT-1:0] reg_valid_ff;

   logic [WORD_W-1:0]    window_low_ff;
   logic [WORD_W-1:0]    window_high_ff;
   logic [WORD_W-1:0]    hi_ff;
   logic [WORD_W-1:0]    lo_ff;

   // Execute stage.
   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic                 s1_adv;
   logic [FUNCT_W-1:0]   s1_kind_ff;
   logic [REG_IDX_W-1:0] s1_dest_ff;
   logic [REG_IDX_W-1:0] s1_shamt_ff;
   logic [WORD_W-1:0]    s1_pc_ff;
   logic [WORD_W-1:0]    rs_mem_ff;
   logic [WORD_W-1:0]    rt_mem_ff;
   logic                 rs_live_ff;
   logic                 rt_live_ff;
   logic                 rs_byp_ff;
   logic                 rt_byp_ff;
   logic [WORD_W-1:0]    byp_value_ff;
   logic [WORD_W-1:0]    rs_value;
   logic [WORD_W-1:0]    rt_value;

   alu_operand_type      alu_op;
   alu_result_type       alu_res;
   logic                 wr_fire;

   // Result register.
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   alu_result_type       rsp_ff;

   assign req_first = req_tdata[4:0];
   assign req_second = req_tdata[9:5];

   assign s1_adv = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire = req_tvalid && req_tready;
   assign wr_fire = s1_adv && alu_res.write_enable;
   assign s1_valid_in = req_fire || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_tready);
   assign csr_ready = 1'b1;

   // Register file: one write port from the execute stage, two registered reads.
   always_ff @(posedge clock) begin
      if (wr_fire) begin
         regs_mem[alu_res.write_index] <= alu_res.write_value;
      end
      if (req_fire) begin
         rs_mem_ff <= regs_mem[req_first];
         rt_mem_ff <= regs_mem[req_second];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_valid_ff <= '0;
      end else if (wr_fire) begin
         reg_valid_ff[alu_res.write_index] <= 1'b1;
      end
   end

   // The memory returns old data on a same-edge write, so that write is captured here.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff <= req_tuser;
         s1_dest_ff <= req_tdata[14:10];
         s1_shamt_ff <= req_tdata[19:15];
         s1_pc_ff <= req_tdata[51:20];
         rs_live_ff <= reg_valid_ff[req_first];
         rt_live_ff <= reg_valid_ff[req_second];
         rs_byp_ff <= wr_fire && (alu_res.write_index == req_first);
         rt_byp_ff <= wr_fire && (alu_res.write_index == req_second);
         byp_value_ff <= alu_res.write_value;
      end
   end

   assign rs_value = rs_byp_ff ? byp_value_ff : (rs_live_ff ? rs_mem_ff : '0);
   assign rt_value = rt_byp_ff ? byp_value_ff : (rt_live_ff ? rt_mem_ff : '0);

   always_comb begin
      alu_op.kind = s1_kind_ff;
      alu_op.dest_index = s1_dest_ff;
      alu_op.shift_amount = s1_shamt_ff;
      alu_op.pc = s1_pc_ff;
      alu_op.rs = rs_value;
      alu_op.rt = rt_value;
      alu_op.hi = hi_ff;
      alu_op.lo = lo_ff;
      alu_op.window_low = window_low_ff;
      alu_op.window_high = window_high_ff;
   end

   mre_alu u_alu (
      .op  (alu_op),
      .res (alu_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hi_ff <= '0;
         lo_ff <= '0;
         window_low_ff <= CODE_WINDOW_LOW_RESET;
         window_high_ff <= CODE_WINDOW_HIGH_RESET;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv && alu_res.hi_write) begin
            hi_ff <= alu_res.hi_value;
         end
         if (s1_adv && alu_res.lo_write) begin
            lo_ff <= alu_res.lo_value;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_CODE_WINDOW_LOW) begin
               window_low_ff <= csr_data;
            end else if (csr_index == CSR_CODE_WINDOW_HIGH) begin
               window_high_ff <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_ff <= alu_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {7'd0, rsp_ff.fault, rsp_ff.jump_target, rsp_ff.jump_taken,
                       rsp_ff.write_value, rsp_ff.write_index, rsp_ff.write_enable};

   // Register zero must never become live.
   a_zero_never_live: assert property (@(posedge clock) disable iff (reset)
      !reg_valid_ff[0])
      else $error("register zero marked as written");

   a_exec_loads_result: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_tvalid)
      else $error("executed request did not reach the result register");

   a_jump_no_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.jump_taken |-> rsp_ff.fault == FAULT_NONE)
      else $error("jump reported together with a fault");

   a_fault_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_ff.fault != FAULT_NONE |-> !rsp_ff.write_enable)
      else $error("faulting instruction wrote a register");

endmodule
